/* src/gbca_pkg.sv */
// Shared types and constants for the gyro bias calibration accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package gbca_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int AXIS_W     = 2;
  // Axes carried on the ports, whether or not the core uses them all.
  localparam int PORT_AXES  = 3;

  // Run phase, reported as the status field of each result.
  typedef enum logic [STATUS_W-1:0] {
    PH_IDLE      = 3'd0,
    PH_COLLECT   = 3'd1,
    PH_READY     = 3'd2,
    PH_FAIL_ABS  = 3'd3,
    PH_FAIL_SPAN = 3'd4
  } phase_t;

  // Command carried by each input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_FEED  = 2'd0,
    MODE_START = 2'd1,
    MODE_ABORT = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [AXIS_W-1:0] NO_AXIS = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ABS      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPAN     = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] TARGET_RST   = 16'd1;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd0;
  localparam logic [CFG_W-1:0] ABS_RST      = 16'd32768;
  localparam logic [CFG_W-1:0] SPAN_RST     = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic apply;
    logic span;
    logic div_start;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_ready;
    logic div_done;
    logic div_last;
  } dp_stat_t;

endpackage

/* src/gbca_div.sv */
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Stand-alone; used by the datapath to form the run means.
module gbca_div #(
  parameter int DIVIDEND_W = 33,
  parameter int DIVISOR_W  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DIVISOR_W-1:0]  divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem;
  logic                  neg;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, work[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // Step counter and handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Magnitude shift register collects the quotient bits as the dividend leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DIVIDEND_W-1];
      work <= dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[DIVIDEND_W-2:0], fits};
      rem  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient = neg ? signed'(~work + 1'b1) : signed'(work);

endmodule

/* src/gbca_ctrl.sv */
// Sequencing state machine of the gyro bias calibration accumulator.
// Depends on gbca_pkg for the command and status structs.
module gbca_ctrl import gbca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_APPLY,
    ST_SPAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span   = 1'b1;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        if (stat.new_ready) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_WAIT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.div_last ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* src/gbca_dp.sv */
// Datapath of the gyro bias calibration accumulator: configuration, run state,
// per-axis min/max/sums, limit checks, mean division and the output register.
// Depends on gbca_pkg and gbca_div.
module gbca_dp import gbca_pkg::*; #(
  parameter int  SAMPLE_BITS = 16,
  parameter int  COUNT_BITS  = 16,
  parameter int  AXES        = 3,
  localparam int IN_W  = ((TIME_W + 2 * PORT_AXES * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((STATUS_W + AXIS_W + 2 * PORT_AXES * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic [MODE_W-1:0]     s_tuser,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tuser
);

  localparam int SUM_W     = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int NUM_MEANS = 2 * AXES;
  localparam int SEL_W     = $clog2(NUM_MEANS);
  localparam int MAG_W     = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int SPAN_W    = (SAMPLE_BITS + 1 > CFG_W) ? SAMPLE_BITS + 1 : CFG_W;
  localparam int CNT_W     = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int OUT_BASE  = STATUS_W + AXIS_W;

  // Configuration registers.
  logic [CFG_W-1:0] target_count;
  logic [CFG_W-1:0] min_interval;
  logic [CFG_W-1:0] abs_limit;
  logic [CFG_W-1:0] span_limit;

  // Captured item.
  mode_t                         mode_q;
  logic [TIME_W-1:0]             now_q;
  logic signed [SAMPLE_BITS-1:0] gyro_q  [AXES];
  logic signed [SAMPLE_BITS-1:0] accel_q [AXES];

  // Run state.
  phase_t                        phase;
  logic [AXIS_W-1:0]             fail_index;
  logic [COUNT_BITS-1:0]         count;
  logic [TIME_W-1:0]             last_time;
  logic                          have_last;
  logic signed [SAMPLE_BITS-1:0] gyro_min [AXES];
  logic signed [SAMPLE_BITS-1:0] gyro_max [AXES];
  logic signed [SUM_W-1:0]       sums     [NUM_MEANS];

  // Per-item working flags and the mean results.
  logic                          skip_q;
  logic                          abs_fail_q;
  logic [AXIS_W-1:0]             abs_axis_q;
  logic                          span_pend;
  logic                          new_ready;
  logic [SEL_W-1:0]              sel;
  logic [SAMPLE_BITS-1:0]        mean_q [NUM_MEANS];
  logic [OUT_W-1:0]              out_next;

  // Combinational checks.
  logic [TIME_W-1:0]      elapsed;
  logic                   too_soon;
  logic [SAMPLE_BITS-1:0] mag [AXES];
  logic                   abs_any;
  logic [AXIS_W-1:0]      abs_axis;
  logic signed [SAMPLE_BITS:0] span_diff [AXES];
  logic                   span_any;
  logic [AXIS_W-1:0]      span_axis;
  logic                   count_done;
  logic                   feed_ok;
  logic                   start_run;
  logic                   clear_run;
  logic                   means_ok;

  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= TARGET_RST;
      min_interval <= INTERVAL_RST;
      abs_limit    <= ABS_RST;
      span_limit   <= SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET:   target_count <= cfg_data;
        REG_INTERVAL: min_interval <= cfg_data;
        REG_ABS:      abs_limit    <= cfg_data;
        REG_SPAN:     span_limit   <= cfg_data;
        default:      target_count <= target_count;
      endcase
    end
  end

  // Interval and magnitude checks on the captured sample.
  always_comb begin
    elapsed  = now_q - last_time;
    too_soon = have_last && (elapsed < TIME_W'(min_interval));
    abs_any  = 1'b0;
    abs_axis = NO_AXIS;
    for (int i = 0; i < AXES; i++) begin
      mag[i] = gyro_q[i][SAMPLE_BITS-1] ? (~gyro_q[i] + 1'b1) : gyro_q[i];
    end
    for (int i = AXES - 1; i >= 0; i--) begin
      if (MAG_W'(mag[i]) > MAG_W'(abs_limit)) begin
        abs_any  = 1'b1;
        abs_axis = AXIS_W'(i);
      end
    end
  end

  // Span check over the stored min and max, lowest failing axis first.
  always_comb begin
    span_any  = 1'b0;
    span_axis = NO_AXIS;
    for (int i = 0; i < AXES; i++) begin
      span_diff[i] = {gyro_max[i][SAMPLE_BITS-1], gyro_max[i]}
                   - {gyro_min[i][SAMPLE_BITS-1], gyro_min[i]};
    end
    for (int i = AXES - 1; i >= 0; i--) begin
      if (SPAN_W'($unsigned(span_diff[i])) > SPAN_W'(span_limit)) begin
        span_any  = 1'b1;
        span_axis = AXIS_W'(i);
      end
    end
  end

  assign count_done = (CNT_W'(count) >= CNT_W'(target_count));
  assign feed_ok    = (mode_q == MODE_FEED) && (phase == PH_COLLECT) && !skip_q;
  assign start_run  = (mode_q == MODE_START) && (target_count != '0);
  assign clear_run  = cmd.apply && (start_run || (mode_q == MODE_ABORT));
  assign means_ok   = (phase == PH_READY) && (count != '0);

  // Run state: start and abort clear it, samples update it, the span step closes the run.
  always_ff @(posedge clk) begin
    if (rst || clear_run) begin
      phase      <= (!rst && start_run) ? PH_COLLECT : PH_IDLE;
      fail_index <= NO_AXIS;
      count      <= '0;
      last_time  <= '0;
      have_last  <= 1'b0;
      span_pend  <= 1'b0;
      new_ready  <= 1'b0;
      sel        <= '0;
      for (int i = 0; i < AXES; i++) begin
        gyro_min[i] <= '0;
        gyro_max[i] <= '0;
      end
      for (int j = 0; j < NUM_MEANS; j++) begin
        sums[j] <= '0;
      end
    end else begin
      if (cmd.apply) begin
        span_pend <= feed_ok && !abs_fail_q;
        if (feed_ok && abs_fail_q) begin
          phase      <= PH_FAIL_ABS;
          fail_index <= abs_axis_q;
        end else if (feed_ok) begin
          for (int i = 0; i < AXES; i++) begin
            if (count == '0 || gyro_q[i] < gyro_min[i]) begin
              gyro_min[i] <= gyro_q[i];
            end
            if (count == '0 || gyro_q[i] > gyro_max[i]) begin
              gyro_max[i] <= gyro_q[i];
            end
            sums[i]        <= sums[i] + SUM_W'(gyro_q[i]);
            sums[AXES + i] <= sums[AXES + i] + SUM_W'(accel_q[i]);
          end
          count     <= count + 1'b1;
          last_time <= now_q;
          have_last <= 1'b1;
        end
      end
      if (cmd.span) begin
        sel <= '0;
        if (span_pend && count_done && span_any) begin
          phase      <= PH_FAIL_SPAN;
          fail_index <= span_axis;
          new_ready  <= 1'b0;
        end else if (span_pend && count_done) begin
          phase      <= PH_READY;
          fail_index <= NO_AXIS;
          new_ready  <= (count != '0);
        end else begin
          new_ready <= 1'b0;
        end
      end
      if (div_done && !stat.div_last) begin
        sel <= sel + 1'b1;
      end
    end
  end

  // Item capture, check flags and mean results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode_t'(s_tuser);
      now_q  <= s_tdata[TIME_W-1:0];
      for (int i = 0; i < AXES; i++) begin
        gyro_q[i]  <= s_tdata[TIME_W + i * SAMPLE_BITS +: SAMPLE_BITS];
        accel_q[i] <= s_tdata[TIME_W + (PORT_AXES + i) * SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (cmd.check) begin
      skip_q     <= too_soon;
      abs_fail_q <= abs_any;
      abs_axis_q <= abs_axis;
    end
    if (div_done) begin
      mean_q[sel] <= div_quot[SAMPLE_BITS-1:0];
    end
  end

  // Shared divider: gyro sums first, then accel sums, each over the count.
  gbca_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sums[sel]),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign stat.new_ready = new_ready;
  assign stat.div_done  = div_done;
  assign stat.div_last  = (sel == SEL_W'(NUM_MEANS - 1));

  // Result payload; means read as zero unless the run is ready.
  always_comb begin
    out_next = '0;
    out_next[STATUS_W-1:0]         = phase;
    out_next[STATUS_W +: AXIS_W]   = fail_index;
    if (means_ok) begin
      for (int j = 0; j < AXES; j++) begin
        out_next[OUT_BASE + j * SAMPLE_BITS +: SAMPLE_BITS] = mean_q[j];
        out_next[OUT_BASE + (PORT_AXES + j) * SAMPLE_BITS +: SAMPLE_BITS] =
          mean_q[AXES + j];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= out_next;
      m_tuser <= means_ok;
    end
  end

endmodule

/* src/gyro_bias_calibration_accumulator.sv */
// Top level of the gyro bias calibration accumulator.
// Depends on gbca_pkg, gbca_ctrl, gbca_dp and gbca_div.
//
// Channel  Direction  Handshake          Contents
// s_*      in         tvalid/tready      tuser: mode; tdata: now_ms, gyro x/y/z, accel x/y/z
// m_*      out        tvalid/tready      tuser: means_valid; tdata: status, failed_axis,
//                                        bias x/y/z, mean_accel x/y/z
// cfg_*    in         write enable only  register index and 16-bit value
//
// After acceptance an item passes through the check, apply, span and divide-go
// states, then, if it completes a ready run, through the shared one-bit-per-cycle
// divider once per gyro and accel mean, and last to the output state, where its
// result is loaded into the output register; no new item is taken until then.
// A new item is taken while the previous result still waits in the output register;
// the next result waits for that register to empty. Reset is synchronous and
// returns the run to idle with the configuration at its default values.
module gyro_bias_calibration_accumulator import gbca_pkg::*; #(
  parameter int  SAMPLE_BITS = 16,
  parameter int  COUNT_BITS  = 16,
  parameter int  AXES        = 3,
  localparam int IN_W  = ((TIME_W + 2 * PORT_AXES * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((STATUS_W + AXIS_W + 2 * PORT_AXES * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_ms, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, zero fill
  input  logic [IN_W-1:0]       s_tdata,
  // mode
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, failed_axis, bias_x, bias_y, bias_z,
  // mean_accel_x, mean_accel_y, mean_accel_z, zero fill
  output logic [OUT_W-1:0]      m_tdata,
  // means_valid
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  gbca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Accumulators, checks, divider and output register.
  gbca_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .AXES        (AXES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
